// File: sv/ffha_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the first-fit heap allocator
// no dependencies

package ffha_pkg;

    localparam int unsigned OFF_W    = 24;
    localparam int unsigned SIZE_W   = 24;
    localparam int unsigned REQ_W    = 24;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned HSIZE_W  = 25;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [HSIZE_W-1:0] SIZE_CAP = 25'h100_0000;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 4'd1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NULL_FREE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 3'd4;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
        logic              free;
    } entry_t;

endpackage

// File: sv/ffha_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port and one registered read port
// no dependencies

module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/first_fit_heap_allocator_core.sv
`timescale 1ns / 1ps
// first-fit heap allocator with coalescing, block table held in one ram
// depends on ffha_pkg and ffha_ram
//
// usage:
// - input channel (in_valid / in_stall) carries one request transaction:
//   command, request_size, free_address
// - output channel (out_valid / out_stall) returns one transaction per request:
//   granted_address and status
// - the config port writes heap_base or heap_size; either write reformats the
//   heap as one free block before the next request is accepted
// - one request at a time; the block table ram is walked one entry per cycle
// - an allocate scans the table for the first free entry that fits and marks it
//   used; a split first shifts the entries above it up by one and writes the new
//   free remainder; no fit ends at the last entry; a free is one merge pass
// - zero-size allocate and free of null skip the table and go straight to done
// - the input reopens as the result is registered into the output register
// - a finished result waits in the output register while out_stall is high;
//   the next request is taken meanwhile and holds its result until it drains
// - after reset the heap is formatted from the reset register values (base 0,
//   64 KiB), then requests are accepted

module first_fit_heap_allocator_core #(
    parameter int MAX_BLOCKS      = 64,
    parameter int HEADER_BYTES    = 16,
    parameter int MIN_SPLIT_SLACK = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ffha_pkg::ADDR_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [ffha_pkg::REQ_W-1:0]          request_size,
    input  logic [ffha_pkg::ADDR_W-1:0]         free_address,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ffha_pkg::ADDR_W-1:0]         granted_address,
    output logic [ffha_pkg::STATUS_W-1:0]       status
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = $bits(ffha_pkg::entry_t);
    localparam int RW = ffha_pkg::HSIZE_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT, S_WNEW, S_WHIT, S_MERGE, S_FLUSH, S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   ptr_reg, ptr_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic                            dv_reg, dv_next;
    logic [CW-1:0]                   hit_reg, hit_next;
    logic [CW-1:0]                   w_reg, w_next;
    logic [CW-1:0]                   count_reg, count_next;
    ffha_pkg::entry_t                ent_reg, ent_next;
    logic                            found_reg, found_next;
    logic [RW-1:0]                   size_reg, size_next;
    logic [ffha_pkg::ADDR_W-1:0]     addr_reg, addr_next;
    logic [ffha_pkg::ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic [ffha_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                            out_valid_reg, out_valid_next;
    logic [ffha_pkg::ADDR_W-1:0]     granted_reg, granted_next;
    logic [ffha_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                            fmt_reg, fmt_next;
    logic [ffha_pkg::ADDR_W-1:0]     heap_base_reg, heap_base_next;
    logic [RW-1:0]                   heap_size_reg, heap_size_next;

    logic                            ram_we;
    logic [IW-1:0]                   ram_waddr;
    logic [EW-1:0]                   ram_wdata;
    logic [IW-1:0]                   ram_raddr;
    logic [EW-1:0]                   ram_rdata;

    ffha_pkg::entry_t                rd_ent;
    logic [RW-1:0]                   total;
    logic [ffha_pkg::SIZE_W-1:0]     size0;
    logic [ffha_pkg::ADDR_W-1:0]     rd_paddr;
    logic                            rd_fit;
    logic                            rd_split;
    logic                            rd_match;
    logic                            rd_free;

    ffha_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_ent = ffha_pkg::entry_t'(ram_rdata);
    assign total  = (heap_size_reg > ffha_pkg::SIZE_CAP) ? ffha_pkg::SIZE_CAP : heap_size_reg;
    assign size0  = (total > RW'(HEADER_BYTES))
                    ? ffha_pkg::SIZE_W'(total - RW'(HEADER_BYTES)) : '0;
    assign rd_paddr = heap_base_reg + ffha_pkg::ADDR_W'(rd_ent.off)
                      + ffha_pkg::ADDR_W'(HEADER_BYTES);
    assign rd_fit   = rd_ent.free && ({1'b0, rd_ent.size} >= size_reg);
    assign rd_split = ((RW+1)'(rd_ent.size) >= (RW+1)'(size_reg) + (RW+1)'(HEADER_BYTES)
                       + (RW+1)'(MIN_SPLIT_SLACK)) && (count_reg < CW'(MAX_BLOCKS));
    assign rd_match = !found_reg && (rd_paddr == addr_reg);
    assign rd_free  = rd_ent.free || rd_match;

    assign in_stall        = (state_reg != S_IDLE) || fmt_reg;
    assign out_valid       = out_valid_reg;
    assign granted_address = granted_reg;
    assign status          = status_reg;

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        idx_next        = ptr_reg;
        dv_next         = 1'b0;
        hit_next        = hit_reg;
        w_next          = w_reg;
        count_next      = count_reg;
        ent_next        = ent_reg;
        found_next      = found_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        granted_next    = granted_reg;
        status_next     = status_reg;
        fmt_next        = fmt_reg;
        heap_base_next  = heap_base_reg;
        heap_size_next  = heap_size_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = ptr_reg[IW-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (fmt_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = {{ffha_pkg::OFF_W{1'b0}}, size0, 1'b1};
                    count_next = CW'(1);
                    fmt_next   = 1'b0;
                end
                else if (in_valid)
                begin
                    ptr_next      = '0;
                    res_addr_next = '0;
                    if (command == ffha_pkg::CMD_ALLOC)
                    begin
                        if (request_size == '0)
                        begin
                            res_status_next = ffha_pkg::ST_ZERO_SIZE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            size_next  = (RW'(request_size) + RW'(3)) & ~RW'(3);
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (free_address == '0)
                        begin
                            res_status_next = ffha_pkg::ST_NULL_FREE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            addr_next  = free_address;
                            found_next = 1'b0;
                            w_next     = '0;
                            state_next = S_MERGE;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (ptr_reg < count_reg)
                begin
                    dv_next  = 1'b1;
                    ptr_next = ptr_reg + CW'(1);
                end
                if (dv_reg)
                begin
                    if (rd_fit)
                    begin
                        dv_next         = 1'b0;
                        hit_next        = idx_reg;
                        ent_next        = rd_ent;
                        res_addr_next   = rd_paddr;
                        res_status_next = ffha_pkg::ST_OK;
                        if (rd_split)
                        begin
                            ptr_next   = count_reg - CW'(1);
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            state_next = S_WHIT;
                        end
                    end
                    else if (idx_reg == count_reg - CW'(1))
                    begin
                        dv_next         = 1'b0;
                        res_addr_next   = '0;
                        res_status_next = ffha_pkg::ST_NO_FIT;
                        state_next      = S_DONE;
                    end
                end
            end

            // move entries above the split point up by one, top first
            S_SHIFT:
            begin
                if (dv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = IW'(idx_reg + CW'(1));
                    ram_wdata = ram_rdata;
                end
                if (ptr_reg > hit_reg)
                begin
                    dv_next  = 1'b1;
                    ptr_next = ptr_reg - CW'(1);
                end
                else if (!dv_reg)
                begin
                    state_next = S_WNEW;
                end
            end

            S_WNEW:
            begin
                ram_we         = 1'b1;
                ram_waddr      = IW'(hit_reg + CW'(1));
                ram_wdata      = {ffha_pkg::OFF_W'(ent_reg.off + ffha_pkg::OFF_W'(HEADER_BYTES)
                                                   + size_reg[ffha_pkg::OFF_W-1:0]),
                                  ffha_pkg::SIZE_W'(ent_reg.size - size_reg[ffha_pkg::SIZE_W-1:0]
                                                    - ffha_pkg::SIZE_W'(HEADER_BYTES)),
                                  1'b1};
                count_next     = count_reg + CW'(1);
                ent_next.size  = size_reg[ffha_pkg::SIZE_W-1:0];
                state_next     = S_WHIT;
            end

            S_WHIT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hit_reg[IW-1:0];
                ram_wdata  = {ent_reg.off, ent_reg.size, 1'b0};
                state_next = S_DONE;
            end

            // mark the matching entry free and coalesce in one pass
            S_MERGE:
            begin
                if (ptr_reg < count_reg)
                begin
                    dv_next  = 1'b1;
                    ptr_next = ptr_reg + CW'(1);
                end
                if (dv_reg)
                begin
                    if (rd_match)
                    begin
                        found_next = 1'b1;
                    end
                    if (idx_reg == '0)
                    begin
                        ent_next = {rd_ent.off, rd_ent.size, rd_free};
                    end
                    else if (ent_reg.free && rd_free)
                    begin
                        ent_next.size = ffha_pkg::SIZE_W'(ent_reg.size + rd_ent.size
                                                          + ffha_pkg::SIZE_W'(HEADER_BYTES));
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = w_reg[IW-1:0];
                        ram_wdata = ent_reg;
                        w_next    = w_reg + CW'(1);
                        ent_next  = {rd_ent.off, rd_ent.size, rd_free};
                    end
                    if (idx_reg == count_reg - CW'(1))
                    begin
                        dv_next    = 1'b0;
                        state_next = S_FLUSH;
                    end
                end
            end

            S_FLUSH:
            begin
                ram_we          = 1'b1;
                ram_waddr       = w_reg[IW-1:0];
                ram_wdata       = ent_reg;
                count_next      = w_reg + CW'(1);
                res_addr_next   = '0;
                res_status_next = found_reg ? ffha_pkg::ST_OK : ffha_pkg::ST_BAD_FREE;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = res_addr_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                ffha_pkg::CFG_HEAP_BASE:
                begin
                    heap_base_next = cfg_data;
                    fmt_next       = 1'b1;
                end
                ffha_pkg::CFG_HEAP_SIZE:
                begin
                    heap_size_next = cfg_data[RW-1:0];
                    fmt_next       = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ptr_reg        <= '0;
            idx_reg        <= '0;
            dv_reg         <= 1'b0;
            hit_reg        <= '0;
            w_reg          <= '0;
            count_reg      <= CW'(1);
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            fmt_reg        <= 1'b1;
            heap_base_reg  <= '0;
            heap_size_reg  <= RW'(65536);
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            idx_reg        <= idx_next;
            dv_reg         <= dv_next;
            hit_reg        <= hit_next;
            w_reg          <= w_next;
            count_reg      <= count_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
            fmt_reg        <= fmt_next;
            heap_base_reg  <= heap_base_next;
            heap_size_reg  <= heap_size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg        <= ent_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        granted_reg    <= granted_next;
        status_reg     <= status_next;
    end

endmodule

// File: tb/sv/first_fit_heap_allocator_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for first_fit_heap_allocator_core: random and directed
// allocate/free transactions checked against an in-bench table predictor
// depends on ffha_pkg and first_fit_heap_allocator_core

module first_fit_heap_allocator_core_tb;

    localparam int MAXB = 64;
    localparam int HDR = 16;
    localparam int SLACK = 16;
    localparam int WATCH_LIMIT = 200000;
    localparam logic [ffha_pkg::CFG_IDX_W-1:0] CFG_UNKNOWN = ffha_pkg::CFG_IDX_W'(7);

    typedef struct {
        logic                        cmd;
        logic [ffha_pkg::REQ_W-1:0]  size;
        logic [ffha_pkg::ADDR_W-1:0] addr;
    } request_t;

    typedef struct {
        logic [ffha_pkg::ADDR_W-1:0]   granted;
        logic [ffha_pkg::STATUS_W-1:0] st;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ffha_pkg::ADDR_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic command = 1'b0;
    logic [ffha_pkg::REQ_W-1:0] request_size = '0;
    logic [ffha_pkg::ADDR_W-1:0] free_address = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [ffha_pkg::ADDR_W-1:0] granted_address;
    logic [ffha_pkg::STATUS_W-1:0] status;

    first_fit_heap_allocator_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .request_size(request_size), .free_address(free_address),
        .out_valid(out_valid), .out_stall(out_stall),
        .granted_address(granted_address), .status(status)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [31:0] heap_base_m;
    logic [24:0] heap_size_m;
    logic [23:0] blk_off [MAXB];
    logic [23:0] blk_size [MAXB];
    logic        blk_free [MAXB];
    int          blk_count;
    logic [31:0] live_addrs [$];

    request_t pending_requests [$];
    answer_t  expected_answers [$];
    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;
    logic [31:0] last_granted = 32'd0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void reformat_heap();
        logic [24:0] total;
        total = heap_size_m > ffha_pkg::SIZE_CAP ? ffha_pkg::SIZE_CAP : heap_size_m;
        for (int i = 0; i < MAXB; i++)
        begin
            blk_off[i] = '0;
            blk_size[i] = '0;
            blk_free[i] = 1'b0;
        end
        blk_size[0] = total > HDR ? 24'(total - HDR) : 24'd0;
        blk_free[0] = 1'b1;
        blk_count = 1;
    endfunction

    function automatic logic [31:0] payload_of(input int i);
        return heap_base_m + 32'(blk_off[i]) + 32'(HDR);
    endfunction

    function automatic void coalesce();
        int w;
        w = 0;
        for (int r = 1; r < blk_count; r++)
        begin
            if (blk_free[w] && blk_free[r])
                blk_size[w] = 24'(32'(blk_size[w]) + 32'(blk_size[r]) + 32'(HDR));
            else
            begin
                w++;
                blk_off[w] = blk_off[r];
                blk_size[w] = blk_size[r];
                blk_free[w] = blk_free[r];
            end
        end
        blk_count = w + 1;
    endfunction

    function automatic answer_t serve_request(input request_t rq);
        answer_t a;
        logic [31:0] sz;
        bit found;
        a.granted = '0;
        a.st = ffha_pkg::ST_OK;
        found = 0;
        if (rq.cmd == ffha_pkg::CMD_ALLOC)
        begin
            sz = 32'(rq.size);
            if (sz == 32'd0)
                a.st = ffha_pkg::ST_ZERO_SIZE;
            else
            begin
                sz = (sz + 32'd3) & ~32'd3;
                for (int i = 0; i < blk_count && !found; i++)
                begin
                    if (blk_free[i] && 32'(blk_size[i]) >= sz)
                    begin
                        if (32'(blk_size[i]) >= sz + 32'(HDR) + 32'(SLACK) && blk_count < MAXB)
                        begin
                            for (int k = blk_count; k > i + 1; k--)
                            begin
                                blk_off[k] = blk_off[k-1];
                                blk_size[k] = blk_size[k-1];
                                blk_free[k] = blk_free[k-1];
                            end
                            blk_off[i+1] = 24'(32'(blk_off[i]) + 32'(HDR) + sz);
                            blk_size[i+1] = 24'(32'(blk_size[i]) - sz - 32'(HDR));
                            blk_free[i+1] = 1'b1;
                            blk_size[i] = 24'(sz);
                            blk_count++;
                        end
                        blk_free[i] = 1'b0;
                        a.granted = payload_of(i);
                        found = 1;
                    end
                end
                if (!found)
                    a.st = ffha_pkg::ST_NO_FIT;
            end
        end
        else
        begin
            if (rq.addr == 32'd0)
                a.st = ffha_pkg::ST_NULL_FREE;
            else
            begin
                for (int i = 0; i < blk_count && !found; i++)
                begin
                    if (payload_of(i) == rq.addr)
                    begin
                        blk_free[i] = 1'b1;
                        found = 1;
                    end
                end
                if (found)
                    coalesce();
                else
                    a.st = ffha_pkg::ST_BAD_FREE;
            end
        end
        return a;
    endfunction

    // driver
    always @(posedge clk)
    begin : driver
        if (in_valid && !in_stall)
            pending_requests.pop_front();
        if (!(in_valid && in_stall))
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                command <= pending_requests[0].cmd;
                request_size <= pending_requests[0].size;
                free_address <= pending_requests[0].addr;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // predict on acceptance
    always @(posedge clk)
    begin : predictor
        request_t rq;
        answer_t a;
        if (rst_n && in_valid && !in_stall)
        begin
            rq.cmd = command;
            rq.size = request_size;
            rq.addr = free_address;
            a = serve_request(rq);
            expected_answers.push_back(a);
            if (a.st == ffha_pkg::ST_OK && command == ffha_pkg::CMD_ALLOC)
                live_addrs.push_back(a.granted);
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        answer_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_answers.size() == 0)
                report("unexpected transaction", granted_address, 32'd0);
            else
            begin
                e = expected_answers.pop_front();
                if (granted_address !== e.granted)
                    report("granted_address", granted_address, e.granted);
                if (status !== e.st)
                    report("status", 32'(status), 32'(e.st));
            end
        end
    end

    // receiver stall
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_cycles > 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCH_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_req(input logic cmd, input logic [23:0] sz, input logic [31:0] ad);
        request_t rq;
        rq.cmd = cmd;
        rq.size = sz;
        rq.addr = ad;
        pending_requests.push_back(rq);
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || expected_answers.size() != 0 || in_valid)
            @(posedge clk);
        repeat (4 * MAXB + 20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ffha_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ffha_pkg::CFG_HEAP_BASE)
        begin
            heap_base_m = val;
            reformat_heap();
        end
        else if (idx == ffha_pkg::CFG_HEAP_SIZE)
        begin
            heap_size_m = val[24:0];
            reformat_heap();
        end
        live_addrs.delete();
        repeat (3) @(posedge clk);
    endtask

    task automatic random_phase(input int n, input int maxsz);
        for (int j = 0; j < n; j++)
        begin
            int pick;
            logic [31:0] ad;
            pick = $urandom_range(99);
            if (pick < 50)
                push_req(ffha_pkg::CMD_ALLOC,
                         pick < 3 ? 24'($urandom) : 24'($urandom_range(maxsz)), $urandom);
            else if (pick < 90 && live_addrs.size() != 0)
            begin
                int k;
                k = $urandom_range(live_addrs.size() - 1);
                ad = live_addrs[k];
                live_addrs.delete(k);
                push_req(ffha_pkg::CMD_FREE, 24'($urandom), ad);
            end
            else if (pick < 95)
                push_req(ffha_pkg::CMD_FREE, 24'($urandom), $urandom);
            else
                push_req(ffha_pkg::CMD_FREE, 24'($urandom), last_granted);
            if (live_addrs.size() != 0)
                last_granted = live_addrs[$];
            // keep predictor-driven free picks current
            while (pending_requests.size() > 4)
                @(posedge clk);
        end
    endtask

    initial
    begin
        heap_base_m = 32'd0;
        heap_size_m = 25'd65536;
        reformat_heap();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed
        push_req(ffha_pkg::CMD_ALLOC, 24'd0, 32'hffff_ffff);
        push_req(ffha_pkg::CMD_ALLOC, 24'd1, 32'd0);
        push_req(ffha_pkg::CMD_ALLOC, 24'hff_ffff, 32'd0);
        push_req(ffha_pkg::CMD_ALLOC, 24'd100, 32'd0);
        push_req(ffha_pkg::CMD_FREE, 24'd0, 32'd0);
        push_req(ffha_pkg::CMD_FREE, 24'hff_ffff, 32'd16);
        push_req(ffha_pkg::CMD_FREE, 24'd0, 32'd16);
        push_req(ffha_pkg::CMD_FREE, 24'd0, 32'd5);
        push_req(ffha_pkg::CMD_FREE, 24'd0, 32'hffff_ffff);
        push_req(ffha_pkg::CMD_ALLOC, 24'd65520, 32'd0);
        push_req(ffha_pkg::CMD_ALLOC, 24'd65000, 32'd0);
        drain();

        write_reg(ffha_pkg::CFG_HEAP_SIZE, 32'd16);
        push_req(ffha_pkg::CMD_ALLOC, 24'd0, 32'd0);
        push_req(ffha_pkg::CMD_ALLOC, 24'd4, 32'd0);
        drain();
        write_reg(ffha_pkg::CFG_HEAP_SIZE, 32'h01ff_ffff);
        write_reg(ffha_pkg::CFG_HEAP_BASE, 32'hffff_fff0);
        push_req(ffha_pkg::CMD_ALLOC, 24'd8, 32'd0);
        push_req(ffha_pkg::CMD_FREE, 24'd0, 32'd0);
        push_req(ffha_pkg::CMD_ALLOC, 24'hff_fff0, 32'd0);
        drain();
        write_reg(ffha_pkg::CFG_HEAP_SIZE, 32'd16777216);
        write_reg(CFG_UNKNOWN, 32'h1234);
        // full table: many small allocations
        for (int j = 0; j < 70; j++)
            push_req(ffha_pkg::CMD_ALLOC, 24'($urandom_range(1, 40)), 32'd0);
        drain();

        // random phases
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 45; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 45; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            case (ph)
                0: write_reg(ffha_pkg::CFG_HEAP_BASE, 32'h1000_0000);
                2: write_reg(ffha_pkg::CFG_HEAP_SIZE, 32'd64);
                4: write_reg(ffha_pkg::CFG_HEAP_SIZE, 32'd2048);
                6: write_reg(ffha_pkg::CFG_HEAP_BASE, $urandom);
                default: write_reg(ffha_pkg::CFG_HEAP_SIZE, $urandom_range(64, 20000));
            endcase
            if (ph == 2)
                hold_cycles = 600;
            random_phase(190, ph == 2 ? 80 : (ph == 4 ? 400 : 1200));
            drain();
        end

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
